### hdl/lp2p_pkg.sv
// ----------------------------------------------------------------------------
// lp2p_pkg
// Shared types, constants and tables of the lidar polar-to-pixel converter.
// ----------------------------------------------------------------------------
`default_nettype none

package lp2p_pkg;

    // Elaboration defaults for the top-level parameters
    localparam int IMAGE_DIM_DEF    = 600;
    localparam int CORDIC_STEPS_DEF = 16;

    // Field and datapath widths
    localparam int ANG_W     = 20;   // angle, 2^-16 rad, signed
    localparam int STEP_W    = 18;   // angle step, signed
    localparam int DIST_W    = 16;   // range, 1/1024 m
    localparam int PPM_W     = 8;    // pixels per meter
    localparam int PROD_W    = DIST_W + PPM_W;
    localparam int GAIN_W    = 16;
    localparam int MAG_W     = PROD_W + GAIN_W;
    localparam int XY_W      = 44;   // CORDIC x/y, 26 fraction bits, covers gain growth
    localparam int FRAC_BITS = 26;
    localparam int PIX_W     = 10;
    localparam int STATUS_W  = 2;
    localparam int ATAN_W    = 17;
    localparam int TAB_IDX_W = 5;    // table holds 17 entries
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int TDATA_W   = 24;   // two pixel fields, padded to bytes

    // Angle constants in 2^-16 rad
    localparam logic signed [ANG_W:0]   PI_Q      = 21'sd205887;
    localparam logic signed [ANG_W:0]   NEG_PI_Q  = -21'sd205887;
    localparam logic signed [ANG_W:0]   TWO_PI_Q  = 21'sd411775;
    localparam logic signed [ANG_W-1:0] PI_Z      = 20'sd205887;
    localparam logic signed [ANG_W-1:0] HALF_PI_Z = 20'sd102944;
    localparam logic [GAIN_W-1:0]       GAIN_Q16  = 16'd39797;

    // Register reset values
    localparam logic [ANG_W-1:0]  ANGLE_START_RST = 20'hCDBC1;   // -205887
    localparam logic [STEP_W-1:0] ANGLE_STEP_RST  = 18'd114;
    localparam logic [DIST_W-1:0] MAX_RANGE_RST   = 16'd12288;
    localparam logic [PPM_W-1:0]  PPM_RST         = 8'd60;

    typedef enum logic [1:0] {
        REG_ANGLE_START = 2'd0,
        REG_ANGLE_STEP  = 2'd1,
        REG_MAX_RANGE   = 2'd2,
        REG_PPM         = 2'd3
    } reg_index_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_PLOTTED  = 2'd0,
        ST_REJECTED = 2'd1,
        ST_OUTSIDE  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_FOLD,
        S_ROT,
        S_CENTER,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic prep;
        logic fold;
        logic rot;
        logic center;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic [ANG_W-1:0]  angle_start;
        logic [STEP_W-1:0] angle_step;
        logic [DIST_W-1:0] max_range;
        logic [PPM_W-1:0]  ppm;
    } cfg_t;

    // Bring an angle in (-3*pi, 3*pi) back to [-pi, pi]
    function automatic logic [ANG_W-1:0] wrap_angle(input logic signed [ANG_W:0] a);
        logic signed [ANG_W:0] r;
        if (a > PI_Q) begin
            r = a - TWO_PI_Q;
        end else if (a < NEG_PI_Q) begin
            r = a + TWO_PI_Q;
        end else begin
            r = a;
        end
        return r[ANG_W-1:0];
    endfunction

    // atan(2^-i) in 2^-16 rad, rounded to nearest
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 17'd51472;
            5'd1:    v = 17'd30386;
            5'd2:    v = 17'd16055;
            5'd3:    v = 17'd8150;
            5'd4:    v = 17'd4091;
            5'd5:    v = 17'd2047;
            5'd6:    v = 17'd1024;
            5'd7:    v = 17'd512;
            5'd8:    v = 17'd256;
            5'd9:    v = 17'd128;
            5'd10:   v = 17'd64;
            5'd11:   v = 17'd32;
            5'd12:   v = 17'd16;
            5'd13:   v = 17'd8;
            5'd14:   v = 17'd4;
            5'd15:   v = 17'd2;
            5'd16:   v = 17'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### hdl/lp2p_regs.sv
// ----------------------------------------------------------------------------
// lp2p_regs
// Configuration register file behind a simple APB port.
// ----------------------------------------------------------------------------
`default_nettype none

module lp2p_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lp2p_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [lp2p_pkg::DATA_W-1:0]    pwdata,
    output logic      [lp2p_pkg::DATA_W-1:0]    prdata,
    output logic                                pready,
    output lp2p_pkg::cfg_t                      cfg
);

    lp2p_pkg::cfg_t       cfg_reg, cfg_next;
    lp2p_pkg::reg_index_t index;
    logic                 wr_en;

    assign index  = lp2p_pkg::reg_index_t'(paddr[lp2p_pkg::ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (index)
                lp2p_pkg::REG_ANGLE_START: cfg_next.angle_start = pwdata[lp2p_pkg::ANG_W-1:0];
                lp2p_pkg::REG_ANGLE_STEP:  cfg_next.angle_step  = pwdata[lp2p_pkg::STEP_W-1:0];
                lp2p_pkg::REG_MAX_RANGE:   cfg_next.max_range   = pwdata[lp2p_pkg::DIST_W-1:0];
                lp2p_pkg::REG_PPM:         cfg_next.ppm         = pwdata[lp2p_pkg::PPM_W-1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (index)
            lp2p_pkg::REG_ANGLE_START: prdata = lp2p_pkg::DATA_W'(cfg_reg.angle_start);
            lp2p_pkg::REG_ANGLE_STEP:  prdata = lp2p_pkg::DATA_W'(cfg_reg.angle_step);
            lp2p_pkg::REG_MAX_RANGE:   prdata = lp2p_pkg::DATA_W'(cfg_reg.max_range);
            lp2p_pkg::REG_PPM:         prdata = lp2p_pkg::DATA_W'(cfg_reg.ppm);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.angle_start <= lp2p_pkg::ANGLE_START_RST;
            cfg_reg.angle_step  <= lp2p_pkg::ANGLE_STEP_RST;
            cfg_reg.max_range   <= lp2p_pkg::MAX_RANGE_RST;
            cfg_reg.ppm         <= lp2p_pkg::PPM_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### hdl/lp2p_ctrl.sv
// ----------------------------------------------------------------------------
// lp2p_ctrl
// Sequencer: accept, angle prep, quadrant fold, CORDIC iterations, centering,
// result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module lp2p_ctrl #(
    parameter int CORDIC_STEPS = lp2p_pkg::CORDIC_STEPS_DEF,
    localparam int ITER_W      = $clog2(CORDIC_STEPS)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output lp2p_pkg::cmd_t     cmd,
    output logic [ITER_W-1:0]  iter
);

    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STEPS - 1);

    lp2p_pkg::state_t  state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_room;

    assign out_room = !out_valid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lp2p_pkg::S_IDLE:   if (s_tvalid) state_next = lp2p_pkg::S_PREP;
            lp2p_pkg::S_PREP:   state_next = lp2p_pkg::S_FOLD;
            lp2p_pkg::S_FOLD:   state_next = lp2p_pkg::S_ROT;
            lp2p_pkg::S_ROT:    if (iter_reg == LAST_ITER) state_next = lp2p_pkg::S_CENTER;
            lp2p_pkg::S_CENTER: state_next = lp2p_pkg::S_FINISH;
            lp2p_pkg::S_FINISH: if (out_room) state_next = lp2p_pkg::S_IDLE;
            default:            state_next = lp2p_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            lp2p_pkg::S_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            lp2p_pkg::S_PREP:   cmd.prep     = 1'b1;
            lp2p_pkg::S_FOLD:   cmd.fold     = 1'b1;
            lp2p_pkg::S_ROT:    cmd.rot      = 1'b1;
            lp2p_pkg::S_CENTER: cmd.center   = 1'b1;
            lp2p_pkg::S_FINISH: cmd.load_out = out_room;
            default:            cmd          = '0;
        endcase
    end

    // Iteration counter and output valid
    always_comb begin
        iter_next = iter_reg;
        if (cmd.fold) begin
            iter_next = '0;
        end else if (cmd.rot) begin
            iter_next = iter_reg + ITER_W'(1);
        end
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign iter     = iter_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lp2p_pkg::S_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### hdl/lp2p_datapath.sv
// ----------------------------------------------------------------------------
// lp2p_datapath
// Beam angle tracking, magnitude scaling, iterative CORDIC rotation and
// pixel bound check with the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lp2p_datapath #(
    parameter int IMAGE_DIM    = lp2p_pkg::IMAGE_DIM_DEF,
    parameter int CORDIC_STEPS = lp2p_pkg::CORDIC_STEPS_DEF,
    localparam int ITER_W      = $clog2(CORDIC_STEPS)
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire lp2p_pkg::cfg_t                  cfg,
    input  wire lp2p_pkg::cmd_t                  cmd,
    input  wire logic [ITER_W-1:0]               iter,
    input  wire logic [lp2p_pkg::DIST_W-1:0]     distance,
    input  wire logic                            infinite,
    input  wire logic                            last_sample,
    output logic      [lp2p_pkg::PIX_W-1:0]      pixel_x,
    output logic      [lp2p_pkg::PIX_W-1:0]      pixel_y,
    output lp2p_pkg::status_t                    status,
    output logic                                 scan_end
);

    localparam int ANG_W = lp2p_pkg::ANG_W;
    localparam int XY_W  = lp2p_pkg::XY_W;
    localparam int FB    = lp2p_pkg::FRAC_BITS;
    localparam int INT_W = XY_W - FB;
    localparam int PIX_W = lp2p_pkg::PIX_W;

    localparam logic signed [XY_W-1:0] CENTER_Q  = XY_W'(IMAGE_DIM / 2) << FB;
    localparam logic signed [XY_W-1:0] ONE_Q     = XY_W'(1) << FB;
    localparam logic signed [XY_W-1:0] NEG_LIMIT = -ONE_Q;
    localparam logic [INT_W-1:0]       DIM_L     = INT_W'(IMAGE_DIM);

    // Angle state
    logic                    scan_start_reg;
    logic [ANG_W-1:0]        beam_angle_reg;
    logic [ANG_W-1:0]        angle_used_reg;
    logic signed [ANG_W-1:0] r_reg;

    // Sample
    logic [lp2p_pkg::PROD_W-1:0] dist_ppm_reg;
    logic [lp2p_pkg::MAG_W-1:0]  mag_reg;
    logic                        reject_reg;
    logic                        last_reg;

    // Rotation
    logic signed [XY_W-1:0]  x_reg, y_reg, sum_x_reg, sum_y_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic                    neg_reg;

    // Output register
    logic [PIX_W-1:0]  pixel_x_reg, pixel_y_reg;
    lp2p_pkg::status_t status_reg;
    logic              scan_end_reg;

    logic signed [ANG_W-1:0] z_fold;
    logic                    neg_fold;
    logic signed [XY_W-1:0]  dx, dy;
    logic signed [ANG_W-1:0] atan_s;
    logic [INT_W-1:0]        cx, cy;
    logic                    ok_x, ok_y;
    lp2p_pkg::status_t       status_next;

    // Quadrant fold into [-pi/2, pi/2]
    always_comb begin
        if (r_reg > lp2p_pkg::HALF_PI_Z) begin
            z_fold   = r_reg - lp2p_pkg::PI_Z;
            neg_fold = 1'b1;
        end else if (r_reg < -lp2p_pkg::HALF_PI_Z) begin
            z_fold   = r_reg + lp2p_pkg::PI_Z;
            neg_fold = 1'b1;
        end else begin
            z_fold   = r_reg;
            neg_fold = 1'b0;
        end
    end

    // One CORDIC micro-rotation
    always_comb begin
        dx     = y_reg >>> iter;
        dy     = x_reg >>> iter;
        atan_s = ANG_W'(lp2p_pkg::atan_entry(lp2p_pkg::TAB_IDX_W'(iter)));
    end

    // Truncate toward zero and check bounds
    always_comb begin
        cx   = sum_x_reg[XY_W-1:FB];
        cy   = sum_y_reg[XY_W-1:FB];
        ok_x = sum_x_reg[XY_W-1] ? (sum_x_reg > NEG_LIMIT) : (cx < DIM_L);
        ok_y = sum_y_reg[XY_W-1] ? (sum_y_reg > NEG_LIMIT) : (cy < DIM_L);
        if (reject_reg) begin
            status_next = lp2p_pkg::ST_REJECTED;
        end else if (ok_x && ok_y) begin
            status_next = lp2p_pkg::ST_PLOTTED;
        end else begin
            status_next = lp2p_pkg::ST_OUTSIDE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_start_reg <= 1'b1;
        end else if (cmd.accept) begin
            scan_start_reg <= last_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            angle_used_reg <= scan_start_reg ? cfg.angle_start : beam_angle_reg;
            dist_ppm_reg   <= lp2p_pkg::PROD_W'(distance) * lp2p_pkg::PROD_W'(cfg.ppm);
            reject_reg     <= infinite || (distance > cfg.max_range);
            last_reg       <= last_sample;
        end
        if (cmd.prep) begin
            r_reg   <= $signed(lp2p_pkg::wrap_angle((ANG_W+1)'($signed(angle_used_reg))));
            mag_reg <= lp2p_pkg::MAG_W'(dist_ppm_reg) * lp2p_pkg::MAG_W'(lp2p_pkg::GAIN_Q16);
        end
        if (cmd.fold) begin
            beam_angle_reg <= lp2p_pkg::wrap_angle((ANG_W+1)'(r_reg)
                                + (ANG_W+1)'($signed(cfg.angle_step)));
            z_reg   <= z_fold;
            neg_reg <= neg_fold;
            x_reg   <= XY_W'(mag_reg);
            y_reg   <= '0;
        end
        if (cmd.rot) begin
            if (!z_reg[ANG_W-1]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_s;
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_s;
            end
        end
        if (cmd.center) begin
            sum_x_reg <= (neg_reg ? -x_reg : x_reg) + CENTER_Q;
            sum_y_reg <= (neg_reg ? -y_reg : y_reg) + CENTER_Q;
        end
        if (cmd.load_out) begin
            status_reg   <= status_next;
            scan_end_reg <= last_reg;
            if (status_next == lp2p_pkg::ST_PLOTTED) begin
                pixel_x_reg <= sum_x_reg[XY_W-1] ? '0 : cx[PIX_W-1:0];
                pixel_y_reg <= sum_y_reg[XY_W-1] ? '0 : cy[PIX_W-1:0];
            end else begin
                pixel_x_reg <= '0;
                pixel_y_reg <= '0;
            end
        end
    end

    assign pixel_x  = pixel_x_reg;
    assign pixel_y  = pixel_y_reg;
    assign status   = status_reg;
    assign scan_end = scan_end_reg;

endmodule

`default_nettype wire

### hdl/lidar_polar_to_pixel.sv
// ----------------------------------------------------------------------------
// lidar_polar_to_pixel
// Converts lidar range samples to image pixel coordinates by CORDIC rotation.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one range sample per item. s_tdata carries distance
//   in 1/1024 m, s_tuser flags an infinite sample, s_tlast marks the last
//   sample of a scan; the beam angle restarts at angle_start after it.
//   Output stream (m_*): one result per sample. m_tdata carries pixel_x and
//   pixel_y, m_tuser the status (plotted, rejected by range, outside image),
//   m_tlast copies the scan end mark.
//   APB port: four registers at byte offsets 0, 4, 8, 12 (angle_start,
//   angle_step, max_range, pixels_per_meter). Write them only while idle.
//   Timing: the block takes one item at a time. An item passes through prep,
//   fold, the micro-rotations of the single shared CORDIC stage, which runs
//   one micro-rotation per cycle, centering and the output load; s_tready rises
//   again in the cycle after the result is loaded into the output register.
//   Stall: a result waits in the output register while m_tready is low; the
//   next item is still taken and rotated, and it holds at the final stage
//   until the output register frees.
//   Reset: aresetn is synchronous, active low; it drops m_tvalid, restores
//   register defaults and starts a new scan.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_polar_to_pixel #(
    parameter int IMAGE_DIM    = lp2p_pkg::IMAGE_DIM_DEF,
    parameter int CORDIC_STEPS = lp2p_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input samples
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [lp2p_pkg::DIST_W-1:0]    s_tdata,   // [15:0] distance
    input  wire logic                           s_tuser,   // [0] infinite
    input  wire logic                           s_tlast,   // last_sample
    // Results
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [lp2p_pkg::TDATA_W-1:0]        m_tdata,   // [9:0] pixel_x, [19:10] pixel_y
    output logic [lp2p_pkg::STATUS_W-1:0]       m_tuser,   // [1:0] status
    output logic                                m_tlast,   // scan_end
    // Configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lp2p_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [lp2p_pkg::DATA_W-1:0]    pwdata,
    output logic      [lp2p_pkg::DATA_W-1:0]    prdata,
    output logic                                pready
);

    localparam int ITER_W = $clog2(CORDIC_STEPS);

    lp2p_pkg::cfg_t                cfg;
    lp2p_pkg::cmd_t                cmd;
    logic [ITER_W-1:0]             iter;
    logic [lp2p_pkg::PIX_W-1:0]    pixel_x, pixel_y;
    lp2p_pkg::status_t             status;
    logic                          scan_end;

    lp2p_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lp2p_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .iter     (iter)
    );

    lp2p_datapath #(
        .IMAGE_DIM    (IMAGE_DIM),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .cmd         (cmd),
        .iter        (iter),
        .distance    (s_tdata),
        .infinite    (s_tuser),
        .last_sample (s_tlast),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .status      (status),
        .scan_end    (scan_end)
    );

    // Pack the result: pixel fields from bit 0 up, zero pad to whole bytes
    assign m_tdata = {{(lp2p_pkg::TDATA_W - 2 * lp2p_pkg::PIX_W){1'b0}}, pixel_y, pixel_x};
    assign m_tuser = status;
    assign m_tlast = scan_end;

endmodule

`default_nettype wire

### hdl/lp2p_checker.sv
// ----------------------------------------------------------------------------
// lp2p_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lp2p_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [lp2p_pkg::TDATA_W-1:0]   m_tdata,
    input wire logic [lp2p_pkg::STATUS_W-1:0]  m_tuser,
    input wire logic                           m_tlast
);

    // Hold a stalled result
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_payload_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // One item in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken during conversion");

    // Unplotted results carry zero coordinates
    a_zero_unplotted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != lp2p_pkg::ST_PLOTTED)
            |-> (m_tdata[2*lp2p_pkg::PIX_W-1:0] == '0))
        else $error("nonzero pixel on unplotted result");

endmodule

bind lidar_polar_to_pixel lp2p_checker u_lp2p_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### sim/lidar_polar_to_pixel_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lidar_polar_to_pixel_test
// Self-checking bench for the lidar polar-to-pixel converter.
// ----------------------------------------------------------------------------
// Drives range samples into the input stream and programs the four APB
// registers between phases. A behavioral model of the beam angle and of the
// CORDIC rotation predicts pixel, status and scan end for every accepted
// sample. Each result is checked against the oldest prediction. Directed
// samples hit field and register extremes, the quadrant fold and the scan
// restart. Random scans then run under several sender and receiver idle mixes,
// including one long receiver hold-off.
// ----------------------------------------------------------------------------

module lidar_polar_to_pixel_test;

    import lp2p_pkg::*;

    localparam int     CLK_HALF      = 5;
    localparam int     RESET_CYCLES  = 6;
    localparam int     CYCLE_LIMIT   = 1000000;
    localparam int     SETTLE_CYCLES = CORDIC_STEPS_DEF + 8;
    localparam int     IMG_DIM       = IMAGE_DIM_DEF;
    localparam int     HOLD_OFF_LEN  = 400;

    // Angles in 2^-16 rad, magnitudes with FRAC_BITS fraction bits
    localparam longint HALF_TURN    = 205887;
    localparam longint QUARTER_TURN = 102944;
    localparam longint FULL_TURN    = 411775;
    localparam longint CORDIC_GAIN  = 39797;
    localparam longint CENTER_Q     = longint'(IMAGE_DIM_DEF / 2) <<< FRAC_BITS;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
        status_t          status;
        logic             scan_end;
    } pixel_result_t;

    // ------------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    wire                  s_tready;
    logic [DIST_W-1:0]    s_tdata  = '0;    // [15:0] distance
    logic                 s_tuser  = 1'b0;  // [0] infinite
    logic                 s_tlast  = 1'b0;  // last sample of a scan
    wire                  m_tvalid;
    logic                 m_tready = 1'b0;
    wire  [TDATA_W-1:0]   m_tdata;          // [9:0] pixel_x, [19:10] pixel_y
    wire  [STATUS_W-1:0]  m_tuser;          // [1:0] status
    wire                  m_tlast;          // scan end
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [ADDR_W-1:0]    paddr    = '0;
    logic [DATA_W-1:0]    pwdata   = '0;
    wire  [DATA_W-1:0]    prdata;
    wire                  pready;

    lidar_polar_to_pixel dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    pixel_result_t expected_pixels[$];
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    int            send_idle_pct  = 0;   // chance per cycle the sender waits
    int            stall_pct      = 0;   // chance per cycle the receiver stalls
    int            hold_off_left  = 0;   // cycles of forced receiver hold-off

    // Register mirror, updated as each APB write lands
    logic [ANG_W-1:0]  cfg_angle_start = ANGLE_START_RST;
    logic [STEP_W-1:0] cfg_angle_step  = ANGLE_STEP_RST;
    logic [DIST_W-1:0] cfg_max_range   = MAX_RANGE_RST;
    logic [PPM_W-1:0]  cfg_ppm         = PPM_RST;

    // Beam tracking: angle of the next sample and whether it opens a scan
    longint beam_angle = longint'($signed(ANGLE_START_RST));
    bit     scan_start = 1'b1;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Fold any angle into [-pi, pi]
    function automatic longint wrap_to_half_turn(longint a);
        longint r;
        r = a % FULL_TURN;
        if (r < 0) r += FULL_TURN;
        if (r > HALF_TURN) r -= FULL_TURN;
        return r;
    endfunction

    // atan(2^-i), rounded to nearest, in 2^-16 rad
    function automatic longint atan_of_step(int i);
        case (i)
            0:  return 51472;
            1:  return 30386;
            2:  return 16055;
            3:  return 8150;
            4:  return 4091;
            5:  return 2047;
            6:  return 1024;
            7:  return 512;
            8:  return 256;
            9:  return 128;
            10: return 64;
            11: return 32;
            12: return 16;
            13: return 8;
            14: return 4;
            15: return 2;
            16: return 1;
            default: return 0;
        endcase
    endfunction

    // Add the image center and drop the fraction toward zero
    function automatic longint to_pixel(longint v);
        longint s;
        s = v + CENTER_Q;
        if (s >= 0) return s >>> FRAC_BITS;
        return -((-s) >>> FRAC_BITS);
    endfunction

    // Advance the beam by one sample and work out the pixel it lands on
    function automatic pixel_result_t project_sample(logic [DIST_W-1:0] sample_dist, logic inf,
                                                     logic last);
        pixel_result_t res;
        longint        used, r, x, y, z, dx, dy, cx, cy;
        bit            fold;
        int            i;
        used = scan_start ? longint'($signed(cfg_angle_start)) : beam_angle;
        r = wrap_to_half_turn(used);
        beam_angle = wrap_to_half_turn(r + longint'($signed(cfg_angle_step)));
        scan_start = last;
        res.pixel_x  = '0;
        res.pixel_y  = '0;
        res.scan_end = last;
        if (inf || sample_dist > cfg_max_range) begin
            res.status = ST_REJECTED;
        end else begin
            // Rotate in the right half plane, negate afterwards for the left one
            fold = 1'b0;
            z = r;
            if (z > QUARTER_TURN) begin
                z -= HALF_TURN;
                fold = 1'b1;
            end else if (z < -QUARTER_TURN) begin
                z += HALF_TURN;
                fold = 1'b1;
            end
            x = longint'(sample_dist) * longint'(cfg_ppm) * CORDIC_GAIN;
            y = 0;
            for (i = 0; i < CORDIC_STEPS_DEF; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx;
                    y += dy;
                    z -= atan_of_step(i);
                end else begin
                    x += dx;
                    y -= dy;
                    z += atan_of_step(i);
                end
            end
            if (fold) begin
                x = -x;
                y = -y;
            end
            cx = to_pixel(x);
            cy = to_pixel(y);
            if (cx >= 0 && cx < IMG_DIM && cy >= 0 && cy < IMG_DIM) begin
                res.pixel_x = PIX_W'(cx);
                res.pixel_y = PIX_W'(cy);
                res.status  = ST_PLOTTED;
            end else begin
                res.status  = ST_OUTSIDE;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Cycle limit: end the run if the block hangs
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("lidar_polar_to_pixel_test: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver hold-off: count down a forced stall requested by a test
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_off_left > 0) hold_off_left <= hold_off_left - 1;
    end

    // ------------------------------------------------------------------------
    // Result side: check every accepted item, then pick the next tready
    // ------------------------------------------------------------------------
    task automatic check_result();
        pixel_result_t exp_res;
        if (expected_pixels.size() == 0) begin
            $error("result with no sample pending: tdata %h tuser %0d tlast %0d",
                   m_tdata, m_tuser, m_tlast);
            mismatch_count++;
        end else begin
            exp_res = expected_pixels.pop_front();
            if (m_tdata[PIX_W-1:0] !== exp_res.pixel_x) begin
                $error("pixel_x: expected %0d, actual %0d",
                       exp_res.pixel_x, m_tdata[PIX_W-1:0]);
                mismatch_count++;
            end
            if (m_tdata[2*PIX_W-1:PIX_W] !== exp_res.pixel_y) begin
                $error("pixel_y: expected %0d, actual %0d",
                       exp_res.pixel_y, m_tdata[2*PIX_W-1:PIX_W]);
                mismatch_count++;
            end
            if (m_tuser !== exp_res.status) begin
                $error("status: expected %0d, actual %0d", exp_res.status, m_tuser);
                mismatch_count++;
            end
            if (m_tlast !== exp_res.scan_end) begin
                $error("scan_end: expected %0d, actual %0d", exp_res.scan_end, m_tlast);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_result();
            // Hold tready low through a hold-off, else stall at random
            m_tready <= (hold_off_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one sample, wait for the handshake, record its prediction.
    // Leave tvalid high on return so a back-to-back item needs no extra edge.
    task automatic send_sample(logic [DIST_W-1:0] sample_dist, logic inf, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample_dist;
        s_tuser  <= inf;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        expected_pixels.push_back(project_sample(sample_dist, inf, last));
    endtask

    // Drop tvalid and wait until every pending result has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
    endtask

    // Drain, then give the block time to return to idle before a register write
    task automatic quiesce();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup cycle, access cycle, then back to idle
    task automatic write_reg(reg_index_t idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ANGLE_START: cfg_angle_start = value[ANG_W-1:0];
            REG_ANGLE_STEP:  cfg_angle_step  = value[STEP_W-1:0];
            REG_MAX_RANGE:   cfg_max_range   = value[DIST_W-1:0];
            REG_PPM:         cfg_ppm         = value[PPM_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Program all four registers in one go while the block is idle
    task automatic write_setup(logic [DATA_W-1:0] start, logic [DATA_W-1:0] step,
                               logic [DATA_W-1:0] max_rng, logic [DATA_W-1:0] ppm);
        quiesce();
        write_reg(REG_ANGLE_START, start);
        write_reg(REG_ANGLE_STEP, step);
        write_reg(REG_MAX_RANGE, max_rng);
        write_reg(REG_PPM, ppm);
    endtask

    // Pick one random register set, biased toward the interesting corners
    task automatic random_setup();
        int          sel;
        int          ang;
        logic [31:0] start, step, max_rng, ppm;
        sel = $urandom_range(99);
        if (sel < 25) begin
            start = $urandom_range(0, 32'hFFFFF);
        end else begin
            ang = int'($urandom_range(0, 411774)) - 205887;
            start = 32'(ang);
        end
        sel = $urandom_range(99);
        if (sel < 50) begin
            ang = int'($urandom_range(0, 2400)) - 1200;
        end else if (sel < 75) begin
            ang = int'($urandom_range(0, 131072)) - 65536;
        end else begin
            ang = int'($urandom_range(0, 32'h3FFFF)) - 131072;
        end
        step = 32'(ang);
        sel = $urandom_range(99);
        if (sel < 20) max_rng = 32'd65535;
        else if (sel < 30) max_rng = $urandom_range(0, 1023);
        else max_rng = $urandom_range(0, 65535);
        sel = $urandom_range(99);
        if (sel < 8) ppm = 32'd0;
        else if (sel < 18) ppm = 32'd255;
        else if (sel < 26) ppm = 32'd1;
        else ppm = $urandom_range(1, 255);
        write_setup(start, step, max_rng, ppm);
    endtask

    // One random sample: mostly inside the image, the rest infinite, at the range edge or random
    task automatic send_random_sample(logic last);
        int                kind, near, d;
        logic [DIST_W-1:0] sample_dist;
        logic              inf;
        kind = $urandom_range(99);
        inf  = 1'b0;
        sample_dist = DIST_W'($urandom_range(0, 65535));
        // Largest distance that still lands inside the image radius
        near = (cfg_ppm == 0) ? 65535 : (300 * 1024) / int'(cfg_ppm);
        if (near > 65535) near = 65535;
        if (near > int'(cfg_max_range)) near = int'(cfg_max_range);
        if (kind < 55) begin
            sample_dist = DIST_W'($urandom_range(0, near));
        end else if (kind < 65) begin
            inf = 1'b1;
        end else if (kind < 80) begin
            d = int'(cfg_max_range) + int'($urandom_range(0, 2)) - 1;
            if (d < 0) d = 0;
            if (d > 65535) d = 65535;
            sample_dist = DIST_W'(d);
        end
        send_sample(sample_dist, inf, last);
    endtask

    // Whole scans of random length, with a few stray scan-end marks
    task automatic run_scans(int item_count);
        int   sent, scan_len, k;
        logic last;
        sent = 0;
        while (sent < item_count) begin
            scan_len = $urandom_range(1, 40);
            for (k = 0; k < scan_len && sent < item_count; k++) begin
                last = (k == scan_len - 1) || ($urandom_range(99) < 3);
                send_random_sample(last);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset register values: center, plotted, outside, range edge, infinite,
    // scan end and restart of the angle
    task automatic test_reset_defaults();
        send_sample(16'd0, 1'b0, 1'b0);
        send_sample(16'd2048, 1'b0, 1'b0);
        send_sample(16'd12288, 1'b0, 1'b0);   // exactly max range, off the image
        send_sample(16'd12289, 1'b0, 1'b0);   // one past max range
        send_sample(16'hFFFF, 1'b0, 1'b0);
        send_sample(16'd100, 1'b1, 1'b0);     // no return
        send_sample(16'd1024, 1'b0, 1'b1);
        send_sample(16'd1024, 1'b0, 1'b0);    // angle restarts here
        send_sample(16'd3000, 1'b0, 1'b1);
    endtask

    // Register extremes: start angles beyond +-pi, steps at both ends,
    // max range 0 and all ones, pixels per meter 0 and 255
    task automatic test_register_extremes();
        write_setup(32'h80000, 32'h1FFFF, 32'd65535, 32'd255);
        send_sample(16'hFFFF, 1'b0, 1'b0);
        send_sample(16'd0, 1'b0, 1'b0);
        send_sample(16'd500, 1'b0, 1'b0);
        send_sample(16'd1000, 1'b0, 1'b1);
        write_setup(32'h7FFFF, 32'h20000, 32'd0, 32'd0);
        send_sample(16'd0, 1'b0, 1'b0);       // zero scale, lands on the center
        send_sample(16'd1, 1'b0, 1'b0);
        send_sample(16'd0, 1'b1, 1'b0);
        send_sample(16'd0, 1'b0, 1'b1);
    endtask

    // Cross the quarter turn where the rotation folds, then change the start
    // angle mid-scan; it must only apply after the next scan end
    task automatic test_fold_and_restart();
        write_setup(32'(QUARTER_TURN), 32'd1, 32'd65535, 32'd1);
        send_sample(16'hFFFF, 1'b0, 1'b0);
        send_sample(16'hFFFF, 1'b0, 1'b0);
        quiesce();
        write_reg(REG_ANGLE_START, 32'(HALF_TURN));
        send_sample(16'd40000, 1'b0, 1'b0);
        send_sample(16'd40000, 1'b0, 1'b1);
        send_sample(16'd40000, 1'b0, 1'b0);
    endtask

    // Hold the receiver off so the block fills and stalls its input, then
    // pause the sender until everything has drained and continue
    task automatic test_backpressure();
        int k;
        random_setup();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_off_left <= HOLD_OFF_LEN;
        for (k = 0; k < 16; k++) send_random_sample(k == 15);
        wait_for_results();
        for (k = 0; k < 8; k++) send_random_sample(k == 7);
    endtask

    // Random scans under each idle mix, two register sets per mix
    task automatic test_random_traffic();
        int mode;
        for (mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 79; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 79; end
                default: begin send_idle_pct = 9; stall_pct = 9; end
            endcase
            repeat (2) begin
                random_setup();
                run_scans(130);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 9;
        stall_pct     = 9;
        test_reset_defaults();
        test_register_extremes();
        test_fold_and_restart();
        test_backpressure();
        test_random_traffic();
        // Let the last results out, then allow a little extra for strays
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("lidar_polar_to_pixel_test: done, clean");
        end else begin
            $display("lidar_polar_to_pixel_test: done, errors");
        end
        $finish;
    end

endmodule
